// ===== design/segint_pkg.sv =====
// ----------------------------------------------------------------------------
// segint_pkg
// Shared types and constants for the segment intersection test pipeline.
// ----------------------------------------------------------------------------
package segint_pkg;

	localparam int NUM_ORIENT = 4;

	// sign of one cross product; colinear is zero=1, neg=0
	typedef struct packed {
		logic neg;
		logic zero;
	} orient_t;

endpackage

// ===== design/segint_diff.sv =====
// ----------------------------------------------------------------------------
// segint_diff
// Stage 1: coordinate differences for the four cross products and the
// x/y extents of both segments.
// ----------------------------------------------------------------------------
module segint_diff
	import segint_pkg::*;
#(
	parameter int COORD_WIDTH = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic signed [COORD_WIDTH-1:0]          a0_x,
	input  logic signed [COORD_WIDTH-1:0]          a0_y,
	input  logic signed [COORD_WIDTH-1:0]          a1_x,
	input  logic signed [COORD_WIDTH-1:0]          a1_y,
	input  logic signed [COORD_WIDTH-1:0]          b0_x,
	input  logic signed [COORD_WIDTH-1:0]          b0_y,
	input  logic signed [COORD_WIDTH-1:0]          b1_x,
	input  logic signed [COORD_WIDTH-1:0]          b1_y,
	output logic                                   valid_s1,
	input  logic                                   ready_s1,
	output logic signed [COORD_WIDTH:0]            qx_s1 [NUM_ORIENT],
	output logic signed [COORD_WIDTH:0]            qy_s1 [NUM_ORIENT],
	output logic signed [COORD_WIDTH:0]            rx_s1 [NUM_ORIENT],
	output logic signed [COORD_WIDTH:0]            ry_s1 [NUM_ORIENT],
	output logic signed [COORD_WIDTH-1:0]          amin_x_s1,
	output logic signed [COORD_WIDTH-1:0]          amax_x_s1,
	output logic signed [COORD_WIDTH-1:0]          amin_y_s1,
	output logic signed [COORD_WIDTH-1:0]          amax_y_s1,
	output logic signed [COORD_WIDTH-1:0]          bmin_x_s1,
	output logic signed [COORD_WIDTH-1:0]          bmax_x_s1,
	output logic signed [COORD_WIDTH-1:0]          bmin_y_s1,
	output logic signed [COORD_WIDTH-1:0]          bmax_y_s1
);

	localparam int W = COORD_WIDTH;

	logic signed [W:0] ext_a0_x, ext_a0_y, ext_a1_x, ext_a1_y;
	logic signed [W:0] ext_b0_x, ext_b0_y, ext_b1_x, ext_b1_y;
	logic              load;

	assign ext_a0_x = {a0_x[W-1], a0_x};
	assign ext_a0_y = {a0_y[W-1], a0_y};
	assign ext_a1_x = {a1_x[W-1], a1_x};
	assign ext_a1_y = {a1_y[W-1], a1_y};
	assign ext_b0_x = {b0_x[W-1], b0_x};
	assign ext_b0_y = {b0_y[W-1], b0_y};
	assign ext_b1_x = {b1_x[W-1], b1_x};
	assign ext_b1_y = {b1_y[W-1], b1_y};

	assign in_ready = !valid_s1 || ready_s1;
	assign load     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			// orient 0/1: B endpoints against A; orient 2/3: A endpoints against B
			qx_s1[0] <= ext_a1_x - ext_a0_x;
			qy_s1[0] <= ext_a1_y - ext_a0_y;
			rx_s1[0] <= ext_b0_x - ext_a0_x;
			ry_s1[0] <= ext_b0_y - ext_a0_y;
			qx_s1[1] <= ext_a1_x - ext_a0_x;
			qy_s1[1] <= ext_a1_y - ext_a0_y;
			rx_s1[1] <= ext_b1_x - ext_a0_x;
			ry_s1[1] <= ext_b1_y - ext_a0_y;
			qx_s1[2] <= ext_b1_x - ext_b0_x;
			qy_s1[2] <= ext_b1_y - ext_b0_y;
			rx_s1[2] <= ext_a0_x - ext_b0_x;
			ry_s1[2] <= ext_a0_y - ext_b0_y;
			qx_s1[3] <= ext_b1_x - ext_b0_x;
			qy_s1[3] <= ext_b1_y - ext_b0_y;
			rx_s1[3] <= ext_a1_x - ext_b0_x;
			ry_s1[3] <= ext_a1_y - ext_b0_y;

			amin_x_s1 <= (a0_x < a1_x) ? a0_x : a1_x;
			amax_x_s1 <= (a0_x < a1_x) ? a1_x : a0_x;
			amin_y_s1 <= (a0_y < a1_y) ? a0_y : a1_y;
			amax_y_s1 <= (a0_y < a1_y) ? a1_y : a0_y;
			bmin_x_s1 <= (b0_x < b1_x) ? b0_x : b1_x;
			bmax_x_s1 <= (b0_x < b1_x) ? b1_x : b0_x;
			bmin_y_s1 <= (b0_y < b1_y) ? b0_y : b1_y;
			bmax_y_s1 <= (b0_y < b1_y) ? b1_y : b0_y;
		end
	end

endmodule

// ===== design/segint_mul.sv =====
// ----------------------------------------------------------------------------
// segint_mul
// Stage 2: the eight cross-product terms and the inclusive range overlap
// checks on x and y.
// ----------------------------------------------------------------------------
module segint_mul
	import segint_pkg::*;
#(
	parameter int COORD_WIDTH = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   valid_s1,
	output logic                                   ready_s1,
	input  logic signed [COORD_WIDTH:0]            qx_s1 [NUM_ORIENT],
	input  logic signed [COORD_WIDTH:0]            qy_s1 [NUM_ORIENT],
	input  logic signed [COORD_WIDTH:0]            rx_s1 [NUM_ORIENT],
	input  logic signed [COORD_WIDTH:0]            ry_s1 [NUM_ORIENT],
	input  logic signed [COORD_WIDTH-1:0]          amin_x_s1,
	input  logic signed [COORD_WIDTH-1:0]          amax_x_s1,
	input  logic signed [COORD_WIDTH-1:0]          amin_y_s1,
	input  logic signed [COORD_WIDTH-1:0]          amax_y_s1,
	input  logic signed [COORD_WIDTH-1:0]          bmin_x_s1,
	input  logic signed [COORD_WIDTH-1:0]          bmax_x_s1,
	input  logic signed [COORD_WIDTH-1:0]          bmin_y_s1,
	input  logic signed [COORD_WIDTH-1:0]          bmax_y_s1,
	output logic                                   valid_s2,
	input  logic                                   ready_s2,
	output logic signed [2*COORD_WIDTH+1:0]        pa_s2 [NUM_ORIENT],
	output logic signed [2*COORD_WIDTH+1:0]        pb_s2 [NUM_ORIENT],
	output logic                                   meet_x_s2,
	output logic                                   meet_y_s2
);

	logic load;

	assign ready_s1 = !valid_s2 || ready_s2;
	assign load     = valid_s1 && ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s1) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int k = 0; k < NUM_ORIENT; k++) begin
				pa_s2[k] <= qx_s1[k] * ry_s1[k];
				pb_s2[k] <= qy_s1[k] * rx_s1[k];
			end
			meet_x_s2 <= (amin_x_s1 <= bmax_x_s1) && (bmin_x_s1 <= amax_x_s1);
			meet_y_s2 <= (amin_y_s1 <= bmax_y_s1) && (bmin_y_s1 <= amax_y_s1);
		end
	end

endmodule

// ===== design/segint_sign.sv =====
// ----------------------------------------------------------------------------
// segint_sign
// Stage 3: subtracts the product pairs and keeps the sign of each cross
// product.
// ----------------------------------------------------------------------------
module segint_sign
	import segint_pkg::*;
#(
	parameter int COORD_WIDTH = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   valid_s2,
	output logic                                   ready_s2,
	input  logic signed [2*COORD_WIDTH+1:0]        pa_s2 [NUM_ORIENT],
	input  logic signed [2*COORD_WIDTH+1:0]        pb_s2 [NUM_ORIENT],
	input  logic                                   meet_x_s2,
	input  logic                                   meet_y_s2,
	output logic                                   valid_s3,
	input  logic                                   ready_s3,
	output orient_t                                orient_s3 [NUM_ORIENT],
	output logic                                   meet_x_s3,
	output logic                                   meet_y_s3
);

	localparam int P = 2 * COORD_WIDTH + 2;

	logic [P:0] cross_diff [NUM_ORIENT];
	logic       load;

	always_comb begin
		for (int k = 0; k < NUM_ORIENT; k++) begin
			cross_diff[k] = {pa_s2[k][P-1], pa_s2[k]} - {pb_s2[k][P-1], pb_s2[k]};
		end
	end

	assign ready_s2 = !valid_s3 || ready_s3;
	assign load     = valid_s2 && ready_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ready_s2) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int k = 0; k < NUM_ORIENT; k++) begin
				orient_s3[k].neg  <= cross_diff[k][P];
				orient_s3[k].zero <= (cross_diff[k] == '0);
			end
			meet_x_s3 <= meet_x_s2;
			meet_y_s3 <= meet_y_s2;
		end
	end

endmodule

// ===== design/segment_intersection_test_core.sv =====
// ----------------------------------------------------------------------------
// segment_intersection_test_core
// Orientation-based intersection test of two 2D segments, four stages deep.
//
//   channel | signals                                   | dir
//   --------+-------------------------------------------+-----
//   in      | in_valid, in_ready, a0_x..b1_y            | in
//   out     | out_valid, out_ready, hit, all_colinear   | out
//
// One item per cycle sustained while out_ready is high; each item passes in order
// through the differences, products, cross-product sign and decision registers.
// arst_n clears the stage valid bits only; the pipeline is empty after reset.
// A stall on out_ready backs up stage by stage; stages with a free slot
// downstream keep filling, so bubbles are squeezed out.
// ----------------------------------------------------------------------------
module segment_intersection_test_core
	import segint_pkg::*;
#(
	parameter int COORD_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [COORD_WIDTH-1:0] a0_x,
	input  logic signed [COORD_WIDTH-1:0] a0_y,
	input  logic signed [COORD_WIDTH-1:0] a1_x,
	input  logic signed [COORD_WIDTH-1:0] a1_y,
	input  logic signed [COORD_WIDTH-1:0] b0_x,
	input  logic signed [COORD_WIDTH-1:0] b0_y,
	input  logic signed [COORD_WIDTH-1:0] b1_x,
	input  logic signed [COORD_WIDTH-1:0] b1_y,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          hit,
	output logic                          all_colinear
);

	logic                          valid_s1, ready_s1;
	logic signed [COORD_WIDTH:0]   qx_s1 [NUM_ORIENT];
	logic signed [COORD_WIDTH:0]   qy_s1 [NUM_ORIENT];
	logic signed [COORD_WIDTH:0]   rx_s1 [NUM_ORIENT];
	logic signed [COORD_WIDTH:0]   ry_s1 [NUM_ORIENT];
	logic signed [COORD_WIDTH-1:0] amin_x_s1, amax_x_s1, amin_y_s1, amax_y_s1;
	logic signed [COORD_WIDTH-1:0] bmin_x_s1, bmax_x_s1, bmin_y_s1, bmax_y_s1;

	logic                            valid_s2, ready_s2;
	logic signed [2*COORD_WIDTH+1:0] pa_s2 [NUM_ORIENT];
	logic signed [2*COORD_WIDTH+1:0] pb_s2 [NUM_ORIENT];
	logic                            meet_x_s2, meet_y_s2;

	logic    valid_s3, ready_s3;
	orient_t orient_s3 [NUM_ORIENT];
	logic    meet_x_s3, meet_y_s3;

	logic valid_s4, hit_s4, col_s4;
	logic col, hit_next;

	segint_diff #(.COORD_WIDTH(COORD_WIDTH)) u_diff (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.a0_x      (a0_x),
		.a0_y      (a0_y),
		.a1_x      (a1_x),
		.a1_y      (a1_y),
		.b0_x      (b0_x),
		.b0_y      (b0_y),
		.b1_x      (b1_x),
		.b1_y      (b1_y),
		.valid_s1  (valid_s1),
		.ready_s1  (ready_s1),
		.qx_s1     (qx_s1),
		.qy_s1     (qy_s1),
		.rx_s1     (rx_s1),
		.ry_s1     (ry_s1),
		.amin_x_s1 (amin_x_s1),
		.amax_x_s1 (amax_x_s1),
		.amin_y_s1 (amin_y_s1),
		.amax_y_s1 (amax_y_s1),
		.bmin_x_s1 (bmin_x_s1),
		.bmax_x_s1 (bmax_x_s1),
		.bmin_y_s1 (bmin_y_s1),
		.bmax_y_s1 (bmax_y_s1)
	);

	segint_mul #(.COORD_WIDTH(COORD_WIDTH)) u_mul (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.ready_s1  (ready_s1),
		.qx_s1     (qx_s1),
		.qy_s1     (qy_s1),
		.rx_s1     (rx_s1),
		.ry_s1     (ry_s1),
		.amin_x_s1 (amin_x_s1),
		.amax_x_s1 (amax_x_s1),
		.amin_y_s1 (amin_y_s1),
		.amax_y_s1 (amax_y_s1),
		.bmin_x_s1 (bmin_x_s1),
		.bmax_x_s1 (bmax_x_s1),
		.bmin_y_s1 (bmin_y_s1),
		.bmax_y_s1 (bmax_y_s1),
		.valid_s2  (valid_s2),
		.ready_s2  (ready_s2),
		.pa_s2     (pa_s2),
		.pb_s2     (pb_s2),
		.meet_x_s2 (meet_x_s2),
		.meet_y_s2 (meet_y_s2)
	);

	segint_sign #(.COORD_WIDTH(COORD_WIDTH)) u_sign (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s2  (valid_s2),
		.ready_s2  (ready_s2),
		.pa_s2     (pa_s2),
		.pb_s2     (pb_s2),
		.meet_x_s2 (meet_x_s2),
		.meet_y_s2 (meet_y_s2),
		.valid_s3  (valid_s3),
		.ready_s3  (ready_s3),
		.orient_s3 (orient_s3),
		.meet_x_s3 (meet_x_s3),
		.meet_y_s3 (meet_y_s3)
	);

	// decision: colinear case uses the extent overlap, otherwise straddle test
	always_comb begin
		col = 1'b1;
		for (int k = 0; k < NUM_ORIENT; k++) begin
			col = col && orient_s3[k].zero;
		end
		if (col) begin
			hit_next = meet_x_s3 && meet_y_s3;
		end else begin
			hit_next = (orient_s3[0] != orient_s3[1]) && (orient_s3[2] != orient_s3[3]);
		end
	end

	assign ready_s3 = !valid_s4 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (ready_s3) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s3 && ready_s3) begin
			hit_s4 <= hit_next;
			col_s4 <= col;
		end
	end

	assign out_valid    = valid_s4;
	assign hit          = hit_s4;
	assign all_colinear = col_s4;

endmodule
